// ===== sv/sxf_pkg.sv =====
package sxf_pkg;

  // Frame control bytes
  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_ETX = 8'h03;
  localparam logic [7:0] BYTE_ENQ = 8'h05;

  // First payload position in a frame (STX at 0, count at 1)
  localparam logic [7:0] POS_FIRST_DATA = 8'd2;
  localparam logic [7:0] POS_COUNT      = 8'd1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_COUNT = 2'd1,
    PH_BODY  = 2'd2,
    PH_CHECK = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_PAYLOAD = 3'd0,
    EV_GOOD    = 3'd1,
    EV_BADSUM  = 3'd2,
    EV_NOEND   = 3'd3,
    EV_ENQ     = 3'd4
  } event_kind_t;

  // One result word from the parser to the output register
  typedef struct packed {
    logic        hit;
    event_kind_t kind;
    logic [7:0]  data;
    logic [7:0]  idx;
  } sxf_result_t;

endpackage

// ===== sv/sxf_in_reg.sv =====
module sxf_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  // Free when empty or when the held word leaves this cycle
  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= rx_byte;
    end
  end

endmodule

// ===== sv/sxf_parser.sv =====
module sxf_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           b,
  input  logic                 advance,
  output sxf_pkg::sxf_result_t res
);

  sxf_pkg::phase_t phase, phase_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] position, position_next;
  logic [7:0] running_xor, running_xor_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= sxf_pkg::PH_IDLE;
      frame_length <= '0;
      position     <= '0;
      running_xor  <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      position     <= position_next;
      running_xor  <= running_xor_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    position_next     = position;
    running_xor_next  = running_xor;
    res.hit  = 1'b0;
    res.kind = sxf_pkg::EV_PAYLOAD;
    res.data = '0;
    res.idx  = '0;
    unique case (phase)
      sxf_pkg::PH_IDLE: begin
        if (b == sxf_pkg::BYTE_ENQ) begin
          res.hit  = 1'b1;
          res.kind = sxf_pkg::EV_ENQ;
        end else if (b == sxf_pkg::BYTE_STX) begin
          phase_next        = sxf_pkg::PH_COUNT;
          position_next     = sxf_pkg::POS_COUNT;
          running_xor_next  = '0;
          frame_length_next = '0;
        end
      end
      sxf_pkg::PH_COUNT: begin
        // Treat a zero count as one; both end on the count byte itself
        frame_length_next = (b == 8'd0) ? 8'd1 : b;
        if (b <= 8'd1) begin
          phase_next    = sxf_pkg::PH_IDLE;
          position_next = '0;
          res.hit       = 1'b1;
          res.kind      = sxf_pkg::EV_NOEND;
        end else begin
          running_xor_next = b;
          position_next    = sxf_pkg::POS_FIRST_DATA;
          phase_next       = sxf_pkg::PH_BODY;
        end
      end
      sxf_pkg::PH_BODY: begin
        if (position < frame_length) begin
          running_xor_next = running_xor ^ b;
          position_next    = position + 8'd1;
          res.hit  = 1'b1;
          res.kind = sxf_pkg::EV_PAYLOAD;
          res.data = b;
          res.idx  = position - sxf_pkg::POS_FIRST_DATA;
        end else if (b == sxf_pkg::BYTE_ETX) begin
          running_xor_next = running_xor ^ b;
          position_next    = position + 8'd1;
          phase_next       = sxf_pkg::PH_CHECK;
        end else begin
          // Missing end marker: re-examine this byte as a sync byte
          if (b == sxf_pkg::BYTE_STX) begin
            phase_next        = sxf_pkg::PH_COUNT;
            position_next     = sxf_pkg::POS_COUNT;
            running_xor_next  = '0;
            frame_length_next = '0;
          end else begin
            phase_next    = sxf_pkg::PH_IDLE;
            position_next = '0;
          end
          res.hit  = 1'b1;
          res.kind = sxf_pkg::EV_NOEND;
        end
      end
      sxf_pkg::PH_CHECK: begin
        phase_next    = sxf_pkg::PH_IDLE;
        position_next = '0;
        res.hit  = 1'b1;
        res.kind = (b == running_xor) ? sxf_pkg::EV_GOOD : sxf_pkg::EV_BADSUM;
      end
      default: begin
        phase_next = sxf_pkg::PH_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/sxf_out_reg.sv =====
module sxf_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  sxf_pkg::sxf_result_t res,
  input  logic                 load,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           event_kind,
  output logic [7:0]           data_byte,
  output logic [7:0]           byte_index
);

  assign room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= load && res.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load && res.hit) begin
      event_kind <= res.kind;
      data_byte  <= res.data;
      byte_index <= res.idx;
    end
  end

endmodule

// ===== sv/stx_etx_xor_frame_receiver_top.sv =====
// STX / count / ETX / XOR-checksum frame receiver.
//
// Input channel (in_valid / in_ready / rx_byte): one received serial byte per
// word. Output channel (out_valid / out_ready / event_kind, data_byte,
// byte_index): at most one event per input word: a payload byte with its
// index, frame good, checksum mismatch, missing end marker, or enquiry.
// Bytes that cause no event (idle noise, STX, a count above one, ETX) produce nothing.
//
// Path: an accepted byte sits in the input register, is parsed by the
// compare/XOR logic, and its event loads into the output register once
// the output register has room.
// Throughput: one byte per cycle while no event waits on a stalled output,
// set by the frame state (phase, length, position, XOR) that every byte updates.
//
// Reset (rst, synchronous): frame state returns to idle, both registers
// empty. When the receiver stalls, an event waits in the output register;
// the input register still takes one more byte, and a byte that makes no
// event keeps flowing. A byte that would make an event holds in the input
// register and in_ready drops until out_ready frees the output.
module stx_etx_xor_frame_receiver_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] event_kind,
  output logic [7:0] data_byte,
  output logic [7:0] byte_index
);

  logic                 held_valid;
  logic [7:0]           held_byte;
  logic                 take;
  logic                 room;
  sxf_pkg::sxf_result_t res;

  // Advance the held byte unless its event has nowhere to go
  assign take = held_valid && (room || !res.hit);

  sxf_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  sxf_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .b       (held_byte),
    .advance (take),
    .res     (res)
  );

  sxf_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .res        (res),
    .load       (take),
    .room       (room),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_kind (event_kind),
    .data_byte  (data_byte),
    .byte_index (byte_index)
  );

  // Reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !held_valid))
    else $error("pipeline not empty after reset");

  // Only payload events carry data and an index
  a_non_payload_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind != sxf_pkg::EV_PAYLOAD) |->
      (data_byte == 8'd0 && byte_index == 8'd0))
    else $error("non-payload event carries data");

  // Payload index stays within a 255-byte frame
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == sxf_pkg::EV_PAYLOAD) |-> (byte_index <= 8'd253))
    else $error("payload index out of range");

  // An event-producing byte blocked by a stalled output blocks the input
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (held_valid && res.hit && out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while event is blocked");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;

  // One row of the byte stream: the byte to send and, for rows whose outcome
  // is plain from the frame rules, the event typed in by hand. Rows with
  // typed low take their expectation from the frame predictor below.
  typedef struct packed {
    logic [7:0]           rx;
    logic                 typed;
    logic                 hit;
    sxf_pkg::event_kind_t kind;
    logic [7:0]           data;
    logic [7:0]           idx;
  } stim_row_t;

  localparam int DIR_ROWS   = 27;
  localparam int RAND_WORDS = 623;
  localparam int SCRIPT_MAX = DIR_ROWS + RAND_WORDS + 300;
  localparam int LIMIT      = 100000;
  // Keep both sides busy every cycle inside this window.
  localparam int CALM_FROM  = 750;
  localparam int CALM_TO    = 950;
  // Receiver hold-off: start once this many words went in, last this long.
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_LEN   = 240;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] event_kind;
  logic [7:0] data_byte;
  logic [7:0] byte_index;

  stx_etx_xor_frame_receiver_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_kind (event_kind),
    .data_byte  (data_byte),
    .byte_index (byte_index)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Directed opening: idle noise, enquiry, counts of zero and one, an empty
  // frame, a frame with extreme payload bytes, a missing end marker that is
  // STX and reopens a frame, a bad checksum, and a missing end marker that is
  // ENQ (dropped, so only the second ENQ reports).
  stim_row_t directed_rows [DIR_ROWS] = '{
    '{8'h00,             1'b1, 1'b0, sxf_pkg::EV_PAYLOAD, 8'h00, 8'h00},
    '{sxf_pkg::BYTE_ENQ, 1'b1, 1'b1, sxf_pkg::EV_ENQ,     8'h00, 8'h00},
    '{sxf_pkg::BYTE_STX, 1'b1, 1'b0, sxf_pkg::EV_PAYLOAD, 8'h00, 8'h00},
    '{8'h00,             1'b1, 1'b1, sxf_pkg::EV_NOEND,   8'h00, 8'h00},
    '{sxf_pkg::BYTE_STX, 1'b1, 1'b0, sxf_pkg::EV_PAYLOAD, 8'h00, 8'h00},
    '{8'h01,             1'b1, 1'b1, sxf_pkg::EV_NOEND,   8'h00, 8'h00},
    '{sxf_pkg::BYTE_STX, 1'b1, 1'b0, sxf_pkg::EV_PAYLOAD, 8'h00, 8'h00},
    '{8'h02,             1'b1, 1'b0, sxf_pkg::EV_PAYLOAD, 8'h00, 8'h00},
    '{sxf_pkg::BYTE_ETX, 1'b1, 1'b0, sxf_pkg::EV_PAYLOAD, 8'h00, 8'h00},
    '{8'h01,             1'b1, 1'b1, sxf_pkg::EV_GOOD,    8'h00, 8'h00},
    '{sxf_pkg::BYTE_STX, 1'b1, 1'b0, sxf_pkg::EV_PAYLOAD, 8'h00, 8'h00},
    '{8'h04,             1'b1, 1'b0, sxf_pkg::EV_PAYLOAD, 8'h00, 8'h00},
    '{8'hFF,             1'b1, 1'b1, sxf_pkg::EV_PAYLOAD, 8'hFF, 8'h00},
    '{8'h00,             1'b1, 1'b1, sxf_pkg::EV_PAYLOAD, 8'h00, 8'h01},
    '{sxf_pkg::BYTE_ETX, 1'b0, 1'b0, sxf_pkg::EV_PAYLOAD, 8'h00, 8'h00},
    '{8'hF8,             1'b0, 1'b0, sxf_pkg::EV_PAYLOAD, 8'h00, 8'h00},
    '{sxf_pkg::BYTE_STX, 1'b1, 1'b0, sxf_pkg::EV_PAYLOAD, 8'h00, 8'h00},
    '{8'h03,             1'b1, 1'b0, sxf_pkg::EV_PAYLOAD, 8'h00, 8'h00},
    '{8'hA5,             1'b0, 1'b0, sxf_pkg::EV_PAYLOAD, 8'h00, 8'h00},
    '{sxf_pkg::BYTE_STX, 1'b1, 1'b1, sxf_pkg::EV_NOEND,   8'h00, 8'h00},
    '{8'h02,             1'b1, 1'b0, sxf_pkg::EV_PAYLOAD, 8'h00, 8'h00},
    '{sxf_pkg::BYTE_ETX, 1'b1, 1'b0, sxf_pkg::EV_PAYLOAD, 8'h00, 8'h00},
    '{8'h00,             1'b1, 1'b1, sxf_pkg::EV_BADSUM,  8'h00, 8'h00},
    '{sxf_pkg::BYTE_STX, 1'b1, 1'b0, sxf_pkg::EV_PAYLOAD, 8'h00, 8'h00},
    '{8'h02,             1'b1, 1'b0, sxf_pkg::EV_PAYLOAD, 8'h00, 8'h00},
    '{sxf_pkg::BYTE_ENQ, 1'b1, 1'b1, sxf_pkg::EV_NOEND,   8'h00, 8'h00},
    '{sxf_pkg::BYTE_ENQ, 1'b1, 1'b1, sxf_pkg::EV_ENQ,     8'h00, 8'h00}
  };

  // Byte script and expected events, each an array with its own counters.
  stim_row_t            rx_script [SCRIPT_MAX];
  sxf_pkg::sxf_result_t pending_events [SCRIPT_MAX];
  stim_row_t            cur_row;

  int script_len  = 0;
  int script_pos  = 0;
  int ev_wr       = 0;
  int ev_rd       = 0;
  int errors      = 0;
  int words_sent  = 0;
  int cycle_count = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;
  bit calm;

  // Frame predictor state, starting from the reset state.
  sxf_pkg::phase_t fr_phase = sxf_pkg::PH_IDLE;
  logic [7:0]      fr_len   = 8'h00;
  logic [7:0]      fr_pos   = 8'h00;
  logic [7:0]      fr_sum   = 8'h00;

  assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

  function automatic void queue_byte(input logic [7:0] b);
    stim_row_t row;
    row      = '0;
    row.rx   = b;
    row.kind = sxf_pkg::EV_PAYLOAD;
    rx_script[script_len] = row;
    script_len++;
  endfunction

  function automatic void open_frame();
    fr_phase = sxf_pkg::PH_COUNT;
    fr_pos   = sxf_pkg::POS_COUNT;
    fr_sum   = 8'h00;
    fr_len   = 8'h00;
  endfunction

  // Advance the frame state by one received byte; hit flags an event.
  function automatic sxf_pkg::sxf_result_t frame_step(input logic [7:0] b);
    sxf_pkg::sxf_result_t r;
    r      = '0;
    r.kind = sxf_pkg::EV_PAYLOAD;
    case (fr_phase)
      sxf_pkg::PH_IDLE: begin
        if (b == sxf_pkg::BYTE_ENQ) begin
          r.hit  = 1'b1;
          r.kind = sxf_pkg::EV_ENQ;
        end else if (b == sxf_pkg::BYTE_STX) begin
          open_frame();
        end
      end
      sxf_pkg::PH_COUNT: begin
        fr_len = (b == 8'h00) ? 8'h01 : b;
        if (fr_len <= 8'h01) begin
          // end marker would land on the count byte itself
          fr_phase = sxf_pkg::PH_IDLE;
          fr_pos   = 8'h00;
          r.hit    = 1'b1;
          r.kind   = sxf_pkg::EV_NOEND;
        end else begin
          fr_sum   = fr_len;
          fr_pos   = sxf_pkg::POS_FIRST_DATA;
          fr_phase = sxf_pkg::PH_BODY;
        end
      end
      sxf_pkg::PH_BODY: begin
        if (fr_pos < fr_len) begin
          r.hit  = 1'b1;
          r.kind = sxf_pkg::EV_PAYLOAD;
          r.data = b;
          r.idx  = fr_pos - sxf_pkg::POS_FIRST_DATA;
          fr_sum = fr_sum ^ b;
          fr_pos = fr_pos + 8'd1;
        end else if (b == sxf_pkg::BYTE_ETX) begin
          fr_sum   = fr_sum ^ b;
          fr_pos   = fr_pos + 8'd1;
          fr_phase = sxf_pkg::PH_CHECK;
        end else begin
          // missing end marker: the byte gets a second look as sync
          if (b == sxf_pkg::BYTE_STX) begin
            open_frame();
          end else begin
            fr_phase = sxf_pkg::PH_IDLE;
            fr_pos   = 8'h00;
          end
          r.hit  = 1'b1;
          r.kind = sxf_pkg::EV_NOEND;
        end
      end
      default: begin
        fr_phase = sxf_pkg::PH_IDLE;
        fr_pos   = 8'h00;
        r.hit    = 1'b1;
        r.kind   = (b == fr_sum) ? sxf_pkg::EV_GOOD : sxf_pkg::EV_BADSUM;
      end
    endcase
    return r;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("ERROR %0s at cycle %0d: got %0h, want %0h", what, cycle_count, got, want);
    errors++;
  endtask

  // Sender, predictor and checker share one process so that an event is
  // taken out and a new expectation added in a fixed order at each edge.
  always @(posedge clk) begin : sender
    sxf_pkg::sxf_result_t want;
    sxf_pkg::sxf_result_t ev;
    stim_row_t            row;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // check an event leaving the block against the oldest expectation
      if (out_valid && out_ready) begin
        if (ev_rd == ev_wr) begin
          report("unexpected event_kind", int'(event_kind), 0);
        end else begin
          want = pending_events[ev_rd];
          ev_rd++;
          if (event_kind != want.kind)
            report("event_kind", int'(event_kind), int'(want.kind));
          if (data_byte != want.data)
            report("data_byte", int'(data_byte), int'(want.data));
          if (byte_index != want.idx)
            report("byte_index", int'(byte_index), int'(want.idx));
        end
      end
      // a word went in: advance the predictor and queue its event, if any
      if (in_valid && in_ready) begin
        ev = frame_step(cur_row.rx);
        if (cur_row.typed) begin
          if (cur_row.hit) begin
            want      = '0;
            want.hit  = 1'b1;
            want.kind = cur_row.kind;
            want.data = cur_row.data;
            want.idx  = cur_row.idx;
            pending_events[ev_wr] = want;
            ev_wr++;
          end
        end else if (ev.hit) begin
          pending_events[ev_wr] = ev;
          ev_wr++;
        end
        words_sent <= words_sent + 1;
      end
      // offer the next word, or idle now and then; hold while unaccepted
      if (!in_valid || in_ready) begin
        if (script_pos < script_len && (calm || $urandom_range(0, 99) >= 30)) begin
          row      = rx_script[script_pos];
          script_pos++;
          cur_row  = row;
          in_valid <= 1'b1;
          rx_byte  <= row.rx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall at random, and once hold off long enough that the block
  // backs up and drops in_ready while the sender keeps offering.
  always @(posedge clk) begin : receiver
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && words_sent >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 30);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("stx_etx_xor_frame_receiver_top: mismatch");
      $finish;
    end
  end

  initial begin : main
    int         pick;
    int         cnt;
    int         flaw;
    logic [7:0] sum;
    logic [7:0] b;
    bit         big_done;
    big_done = 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      rx_script[script_len] = directed_rows[i];
      script_len++;
    end

    // Random part: mostly well-formed frames with random payload, plus
    // noise, enquiries, short counts, missing end markers and bad sums.
    while (script_len < DIR_ROWS + RAND_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        queue_byte(8'($urandom_range(0, 255)));
      end else if (pick < 14) begin
        queue_byte(sxf_pkg::BYTE_ENQ);
      end else if (pick < 18) begin
        queue_byte(sxf_pkg::BYTE_STX);
        queue_byte(8'($urandom_range(0, 1)));
      end else begin
        // one frame of maximum length reaches the top payload index
        if (!big_done && script_len > 200) begin
          cnt      = 255;
          big_done = 1'b1;
        end else begin
          cnt = (pick < 30) ? 2 : $urandom_range(3, 12);
        end
        queue_byte(sxf_pkg::BYTE_STX);
        queue_byte(cnt[7:0]);
        sum = cnt[7:0];
        for (int i = 2; i < cnt; i++) begin
          // sprinkle control codes into the payload, where they are plain data
          if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
              0:       b = sxf_pkg::BYTE_STX;
              1:       b = sxf_pkg::BYTE_ETX;
              default: b = sxf_pkg::BYTE_ENQ;
            endcase
          end else begin
            b = 8'($urandom_range(0, 255));
          end
          queue_byte(b);
          sum = sum ^ b;
        end
        flaw = $urandom_range(0, 99);
        if (flaw < 10) begin
          // drop the end marker; STX half the time so a frame reopens
          b = 8'($urandom_range(0, 255));
          if (b == sxf_pkg::BYTE_ETX) b = ~b;
          queue_byte(($urandom_range(0, 1) != 0) ? sxf_pkg::BYTE_STX : b);
        end else begin
          queue_byte(sxf_pkg::BYTE_ETX);
          sum = sum ^ sxf_pkg::BYTE_ETX;
          queue_byte((flaw < 22) ? (sum ^ 8'($urandom_range(1, 255))) : sum);
        end
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Wait for every word to go in and every event to come out, then drain.
    while (script_pos < script_len || in_valid || ev_rd != ev_wr)
      @(posedge clk);
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("stx_etx_xor_frame_receiver_top: match");
    end else begin
      $display("stx_etx_xor_frame_receiver_top: mismatch");
    end
    $finish;
  end

endmodule
